// ----- rtl/qhkl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qhkl_pkg
// widths, constants and helpers for the momentum transfer to hkl core
// ----------------------------------------------------------------------------
package qhkl_pkg;

   localparam int Q_WIDTH     = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_W       = 63;

   localparam int SLOT_W      = 21;
   localparam int PM_W        = 2 * SLOT_W;
   localparam int SM_W        = PM_W + 2;
   localparam int M_DROP      = 18;
   localparam int M_W         = SM_W - M_DROP;
   localparam int CP_W        = 2 * M_W;
   localparam int ADJ_W       = CP_W + 1;
   localparam int LO_W        = 27;
   localparam int HI_W        = ADJ_W - LO_W;
   localparam int DLP_W       = M_W + LO_W + 1;
   localparam int DHP_W       = M_W + HI_W;
   localparam int DT_W        = M_W + ADJ_W;
   localparam int DET_W       = DT_W + 2;
   localparam int NLP_W       = LO_W + 1 + Q_WIDTH;
   localparam int NHP_W       = HI_W + Q_WIDTH;
   localparam int NT_W        = ADJ_W + Q_WIDTH;
   localparam int NUM_W       = NT_W + 2;

   localparam int TWO_PI_W    = 29;
   localparam logic [TWO_PI_W-1:0] TWO_PI_Q = 29'd421657428;
   localparam int DSEG_W      = 27;
   localparam int DSEGS       = (DET_W + DSEG_W - 1) / DSEG_W;
   localparam int DPP_W       = DSEG_W + TWO_PI_W;
   localparam int DEN_W       = DET_W + TWO_PI_W;

   localparam int EXTRA_SHIFT = 44;
   localparam int QB          = Q_WIDTH + 2;
   localparam int CW          = DEN_W + QB + 1;

   localparam int STATUS_W    = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SINGULAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GONIO_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GONIO_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GONIO_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_ROW0   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_ROW1   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_ROW2   = 3'd5;

   localparam logic [CSR_W-1:0] ROW0_RESET = 63'd262144;
   localparam logic [CSR_W-1:0] ROW1_RESET = 63'd549755813888;
   localparam logic [CSR_W-1:0] ROW2_RESET = 63'd1152921504606846976;

   function automatic logic signed [SLOT_W-1:0] slot(input logic [CSR_W-1:0] word,
                                                      input int k);
      slot = $signed(word[k*SLOT_W +: SLOT_W]);
   endfunction

endpackage

// ----- rtl/q_to_hkl_transform_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_to_hkl_transform_core
// momentum transfer vector to miller index coordinates via (R.B)^-1 q / 2pi
//
//   channel   dir   handshake                 contents
//   req_      in    tvalid/tready             tdata: q_x, q_y, q_z
//   rsp_      out   tvalid/tready             tdata: index_h/k/l, tuser: status
//   csr_      in    csr_valid/csr_ready       csr_index, csr_data
//
// one word per cycle in and out while the output is not stalled; 46 pipeline
// stages and the output register, with 34 one-bit restoring division stages
// reset is synchronous and clears valid bits and registers to identity
// a stalled output holds one more word in a skid register, then the whole
// pipeline halts together without loss
// ----------------------------------------------------------------------------
module q_to_hkl_transform_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [3*qhkl_pkg::Q_WIDTH-1:0]      req_tdata,  // q_x, q_y, q_z
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [3*qhkl_pkg::Q_WIDTH-1:0]      rsp_tdata,  // index_h, index_k, index_l
   output logic [qhkl_pkg::STATUS_W-1:0]       rsp_tuser,  // status
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qhkl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qhkl_pkg::CSR_W-1:0]          csr_data
);

   localparam int W      = qhkl_pkg::Q_WIDTH;
   localparam int QB     = qhkl_pkg::QB;
   localparam int CW     = qhkl_pkg::CW;
   localparam int DIV0   = 10;
   localparam int FIN    = DIV0 + QB + 1;
   localparam int NST    = FIN + 1;
   localparam int OUT_W  = 3 * W;

   localparam logic signed [qhkl_pkg::SM_W-1:0] M_HALF =
      qhkl_pkg::SM_W'(1) <<< (qhkl_pkg::M_DROP - 1);
   localparam logic [QB-1:0] HALF_Q = QB'(1) << (W - 1);
   localparam logic [W-1:0]  HALF_W = W'(1) << (W - 1);

   // cofactor operand indices into the row-major m array: a*b - c*d
   localparam int COF_IDX [9][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   typedef struct packed {
      logic [CW-1:0] rem;
      logic [QB-1:0] quo;
      logic          ovf;
   } div_lane_type;

   // configuration
   logic [qhkl_pkg::CSR_W-1:0] gon_ff [3];
   logic [qhkl_pkg::CSR_W-1:0] lat_ff [3];

   // control
   logic [NST-1:0] vld_ff;
   logic           en;
   logic           out_vld_ff;
   logic           skid_vld_ff;

   // stage registers
   logic signed [qhkl_pkg::PM_W-1:0]   s0_pm_ff  [3][3][3];
   logic signed [W-1:0]                s0_q_ff   [3];
   logic signed [qhkl_pkg::M_W-1:0]    s1_m_ff   [9];
   logic signed [W-1:0]                s1_q_ff   [3];
   logic signed [qhkl_pkg::CP_W-1:0]   s2_cp_ff  [9][2];
   logic signed [qhkl_pkg::M_W-1:0]    s2_m0_ff  [3];
   logic signed [W-1:0]                s2_q_ff   [3];
   logic signed [qhkl_pkg::ADJ_W-1:0]  s3_adj_ff [9];
   logic signed [qhkl_pkg::M_W-1:0]    s3_m0_ff  [3];
   logic signed [W-1:0]                s3_q_ff   [3];
   logic signed [qhkl_pkg::DLP_W-1:0]  s4_dlp_ff [3];
   logic signed [qhkl_pkg::DHP_W-1:0]  s4_dhp_ff [3];
   logic signed [qhkl_pkg::NLP_W-1:0]  s4_nlp_ff [3][3];
   logic signed [qhkl_pkg::NHP_W-1:0]  s4_nhp_ff [3][3];
   logic signed [qhkl_pkg::DT_W-1:0]   s5_dt_ff  [3];
   logic signed [qhkl_pkg::NT_W-1:0]   s5_nt_ff  [3][3];
   logic signed [qhkl_pkg::DET_W-1:0]  s6_det_ff;
   logic signed [qhkl_pkg::NUM_W-1:0]  s6_num_ff [3];
   logic [qhkl_pkg::DET_W-1:0]         s7_dmag_ff;
   logic                               s7_dneg_ff;
   logic                               s7_dzero_ff;
   logic [qhkl_pkg::NUM_W-1:0]         s7_nmag_ff [3];
   logic                               s7_nneg_ff [3];
   logic [qhkl_pkg::DPP_W-1:0]         s8_dpp_ff  [qhkl_pkg::DSEGS];
   logic [qhkl_pkg::NUM_W-1:0]         s8_nmag_ff [3];
   logic                               s8_neg_ff  [3];
   logic                               s8_zero_ff;
   logic [qhkl_pkg::DEN_W-1:0]         s9_den_ff;
   logic [qhkl_pkg::NUM_W-1:0]         s9_nmag_ff [3];
   logic                               s9_neg_ff  [3];
   logic                               s9_zero_ff;
   div_lane_type                       dv_ff      [QB+1][3];
   logic [qhkl_pkg::DEN_W-1:0]         dv_den_ff  [QB+1];
   logic                               dv_neg_ff  [QB+1][3];
   logic                               dv_zero_ff [QB+1];
   logic [OUT_W-1:0]                   fin_data_ff;
   logic [qhkl_pkg::STATUS_W-1:0]      fin_stat_ff;
   logic [OUT_W-1:0]                   out_data_ff;
   logic [qhkl_pkg::STATUS_W-1:0]      out_stat_ff;
   logic [OUT_W-1:0]                   skid_data_ff;
   logic [qhkl_pkg::STATUS_W-1:0]      skid_stat_ff;

   // next values
   logic signed [qhkl_pkg::PM_W-1:0]   s0_pm_in  [3][3][3];
   logic signed [qhkl_pkg::M_W-1:0]    s1_m_in   [9];
   logic signed [qhkl_pkg::CP_W-1:0]   s2_cp_in  [9][2];
   logic signed [qhkl_pkg::ADJ_W-1:0]  s3_adj_in [9];
   logic signed [qhkl_pkg::DLP_W-1:0]  s4_dlp_in [3];
   logic signed [qhkl_pkg::DHP_W-1:0]  s4_dhp_in [3];
   logic signed [qhkl_pkg::NLP_W-1:0]  s4_nlp_in [3][3];
   logic signed [qhkl_pkg::NHP_W-1:0]  s4_nhp_in [3][3];
   logic signed [qhkl_pkg::DT_W-1:0]   s5_dt_in  [3];
   logic signed [qhkl_pkg::NT_W-1:0]   s5_nt_in  [3][3];
   logic signed [qhkl_pkg::DET_W-1:0]  s6_det_in;
   logic signed [qhkl_pkg::NUM_W-1:0]  s6_num_in [3];
   logic [qhkl_pkg::DET_W-1:0]         s7_dmag_in;
   logic [qhkl_pkg::NUM_W-1:0]         s7_nmag_in [3];
   logic [qhkl_pkg::DPP_W-1:0]         s8_dpp_in  [qhkl_pkg::DSEGS];
   logic [qhkl_pkg::DEN_W-1:0]         s9_den_in;
   div_lane_type                       dv_in      [QB+1][3];
   logic [OUT_W-1:0]                   fin_data_in;
   logic [qhkl_pkg::STATUS_W-1:0]      fin_stat_in;

   assign en         = !skid_vld_ff;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_stat_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gon_ff[0] <= qhkl_pkg::ROW0_RESET;
         gon_ff[1] <= qhkl_pkg::ROW1_RESET;
         gon_ff[2] <= qhkl_pkg::ROW2_RESET;
         lat_ff[0] <= qhkl_pkg::ROW0_RESET;
         lat_ff[1] <= qhkl_pkg::ROW1_RESET;
         lat_ff[2] <= qhkl_pkg::ROW2_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            qhkl_pkg::CSR_GONIO_ROW0: gon_ff[0] <= csr_data;
            qhkl_pkg::CSR_GONIO_ROW1: gon_ff[1] <= csr_data;
            qhkl_pkg::CSR_GONIO_ROW2: gon_ff[2] <= csr_data;
            qhkl_pkg::CSR_LAT_ROW0:   lat_ff[0] <= csr_data;
            qhkl_pkg::CSR_LAT_ROW1:   lat_ff[1] <= csr_data;
            qhkl_pkg::CSR_LAT_ROW2:   lat_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 0: element products of r.b
   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++)
               s0_pm_in[i][j][k] = qhkl_pkg::PM_W'(qhkl_pkg::slot(gon_ff[i], k))
                                 * qhkl_pkg::PM_W'(qhkl_pkg::slot(lat_ff[k], j));
   end

   // stage 1: sum and round to q7.18
   always_comb begin
      logic signed [qhkl_pkg::SM_W-1:0] s;
      s = '0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            s = qhkl_pkg::SM_W'(s0_pm_ff[i][j][0]) + qhkl_pkg::SM_W'(s0_pm_ff[i][j][1])
              + qhkl_pkg::SM_W'(s0_pm_ff[i][j][2]) + M_HALF;
            s1_m_in[i*3+j] = qhkl_pkg::M_W'(s >>> qhkl_pkg::M_DROP);
         end
   end

   // stage 2: cofactor products, stage 3: adjugate
   always_comb begin
      for (int n = 0; n < 9; n++) begin
         s2_cp_in[n][0] = qhkl_pkg::CP_W'(s1_m_ff[COF_IDX[n][0]])
                        * qhkl_pkg::CP_W'(s1_m_ff[COF_IDX[n][1]]);
         s2_cp_in[n][1] = qhkl_pkg::CP_W'(s1_m_ff[COF_IDX[n][2]])
                        * qhkl_pkg::CP_W'(s1_m_ff[COF_IDX[n][3]]);
         s3_adj_in[n]   = qhkl_pkg::ADJ_W'(s2_cp_ff[n][0])
                        - qhkl_pkg::ADJ_W'(s2_cp_ff[n][1]);
      end
   end

   // stage 4: split partial products for det and numerators
   always_comb begin
      logic signed [qhkl_pkg::LO_W:0]   lo;
      logic signed [qhkl_pkg::HI_W-1:0] hi;
      for (int j = 0; j < 3; j++) begin
         lo = $signed({1'b0, s3_adj_ff[j*3][qhkl_pkg::LO_W-1:0]});
         hi = $signed(s3_adj_ff[j*3][qhkl_pkg::ADJ_W-1:qhkl_pkg::LO_W]);
         s4_dlp_in[j] = qhkl_pkg::DLP_W'(s3_m0_ff[j]) * qhkl_pkg::DLP_W'(lo);
         s4_dhp_in[j] = qhkl_pkg::DHP_W'(s3_m0_ff[j]) * qhkl_pkg::DHP_W'(hi);
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            lo = $signed({1'b0, s3_adj_ff[i*3+j][qhkl_pkg::LO_W-1:0]});
            hi = $signed(s3_adj_ff[i*3+j][qhkl_pkg::ADJ_W-1:qhkl_pkg::LO_W]);
            s4_nlp_in[i][j] = qhkl_pkg::NLP_W'(lo) * qhkl_pkg::NLP_W'(s3_q_ff[j]);
            s4_nhp_in[i][j] = qhkl_pkg::NHP_W'(hi) * qhkl_pkg::NHP_W'(s3_q_ff[j]);
         end
   end

   // stage 5: recombine partials, stage 6: sums
   always_comb begin
      for (int j = 0; j < 3; j++)
         s5_dt_in[j] = (qhkl_pkg::DT_W'(s4_dhp_ff[j]) <<< qhkl_pkg::LO_W)
                     + qhkl_pkg::DT_W'(s4_dlp_ff[j]);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            s5_nt_in[i][j] = (qhkl_pkg::NT_W'(s4_nhp_ff[i][j]) <<< qhkl_pkg::LO_W)
                           + qhkl_pkg::NT_W'(s4_nlp_ff[i][j]);
      s6_det_in = qhkl_pkg::DET_W'(s5_dt_ff[0]) + qhkl_pkg::DET_W'(s5_dt_ff[1])
                + qhkl_pkg::DET_W'(s5_dt_ff[2]);
      for (int i = 0; i < 3; i++)
         s6_num_in[i] = qhkl_pkg::NUM_W'(s5_nt_ff[i][0]) + qhkl_pkg::NUM_W'(s5_nt_ff[i][1])
                      + qhkl_pkg::NUM_W'(s5_nt_ff[i][2]);
   end

   // stage 7: magnitudes, stage 8/9: divisor |det| * 2pi
   always_comb begin
      logic [qhkl_pkg::DSEG_W*qhkl_pkg::DSEGS-1:0] dpad;
      s7_dmag_in = s6_det_ff[qhkl_pkg::DET_W-1] ? qhkl_pkg::DET_W'(-s6_det_ff)
                                                 : qhkl_pkg::DET_W'(s6_det_ff);
      for (int i = 0; i < 3; i++)
         s7_nmag_in[i] = s6_num_ff[i][qhkl_pkg::NUM_W-1] ? qhkl_pkg::NUM_W'(-s6_num_ff[i])
                                                         : qhkl_pkg::NUM_W'(s6_num_ff[i]);
      dpad = (qhkl_pkg::DSEG_W*qhkl_pkg::DSEGS)'(s7_dmag_ff);
      for (int k = 0; k < qhkl_pkg::DSEGS; k++)
         s8_dpp_in[k] = qhkl_pkg::DPP_W'(dpad[k*qhkl_pkg::DSEG_W +: qhkl_pkg::DSEG_W])
                      * qhkl_pkg::DPP_W'(qhkl_pkg::TWO_PI_Q);
      s9_den_in = '0;
      for (int k = 0; k < qhkl_pkg::DSEGS; k++)
         s9_den_in = s9_den_in
                   + (qhkl_pkg::DEN_W'(s8_dpp_ff[k]) << (k*qhkl_pkg::DSEG_W));
   end

   // division: range check, then one quotient bit per stage
   always_comb begin
      logic [CW-1:0] x;
      logic [CW-1:0] dv;
      logic          ge;
      for (int l = 0; l < 3; l++) begin
         x = CW'(s9_nmag_ff[l]) << (qhkl_pkg::EXTRA_SHIFT + 1);
         dv_in[0][l].rem = x;
         dv_in[0][l].quo = '0;
         dv_in[0][l].ovf = (x >= (CW'(s9_den_ff) << QB));
      end
      for (int d = 1; d <= QB; d++)
         for (int l = 0; l < 3; l++) begin
            dv = CW'(dv_den_ff[d-1]) << (QB - d);
            ge = (dv_ff[d-1][l].rem >= dv);
            dv_in[d][l].rem = ge ? dv_ff[d-1][l].rem - dv : dv_ff[d-1][l].rem;
            dv_in[d][l].quo = dv_ff[d-1][l].quo | (QB'(ge) << (QB - d));
            dv_in[d][l].ovf = dv_ff[d-1][l].ovf;
         end
   end

   // final: round half away, saturate, sign
   always_comb begin
      logic [QB:0]   r_full;
      logic [QB-1:0] r;
      logic [QB-1:0] lim;
      logic          sat;
      logic          any_sat;
      logic [W-1:0]  v;
      any_sat = 1'b0;
      fin_data_in = '0;
      for (int l = 0; l < 3; l++) begin
         r_full = (QB+1)'(dv_ff[QB][l].quo) + (QB+1)'(1);
         r      = r_full[QB:1];
         lim    = dv_neg_ff[QB][l] ? HALF_Q : HALF_Q - QB'(1);
         sat    = dv_ff[QB][l].ovf || (r > lim);
         if (sat)
            v = dv_neg_ff[QB][l] ? HALF_W : HALF_W - W'(1);
         else
            v = dv_neg_ff[QB][l] ? W'(-r) : W'(r);
         any_sat = any_sat | sat;
         fin_data_in[l*W +: W] = dv_zero_ff[QB] ? '0 : v;
      end
      if (dv_zero_ff[QB])
         fin_stat_in = qhkl_pkg::STATUS_SINGULAR;
      else if (any_sat)
         fin_stat_in = qhkl_pkg::STATUS_SAT;
      else
         fin_stat_in = qhkl_pkg::STATUS_OK;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid};
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         s0_pm_ff <= s0_pm_in;
         for (int i = 0; i < 3; i++)
            s0_q_ff[i] <= $signed(req_tdata[i*W +: W]);
         s1_m_ff   <= s1_m_in;
         s1_q_ff   <= s0_q_ff;
         s2_cp_ff  <= s2_cp_in;
         for (int j = 0; j < 3; j++)
            s2_m0_ff[j] <= s1_m_ff[j];
         s2_q_ff   <= s1_q_ff;
         s3_adj_ff <= s3_adj_in;
         s3_m0_ff  <= s2_m0_ff;
         s3_q_ff   <= s2_q_ff;
         s4_dlp_ff <= s4_dlp_in;
         s4_dhp_ff <= s4_dhp_in;
         s4_nlp_ff <= s4_nlp_in;
         s4_nhp_ff <= s4_nhp_in;
         s5_dt_ff  <= s5_dt_in;
         s5_nt_ff  <= s5_nt_in;
         s6_det_ff <= s6_det_in;
         s6_num_ff <= s6_num_in;
         s7_dmag_ff  <= s7_dmag_in;
         s7_dneg_ff  <= s6_det_ff[qhkl_pkg::DET_W-1];
         s7_dzero_ff <= (s6_det_ff == '0);
         s7_nmag_ff  <= s7_nmag_in;
         for (int i = 0; i < 3; i++) begin
            s7_nneg_ff[i] <= s6_num_ff[i][qhkl_pkg::NUM_W-1];
            s8_neg_ff[i]  <= s7_nneg_ff[i] ^ s7_dneg_ff;
         end
         s8_dpp_ff  <= s8_dpp_in;
         s8_nmag_ff <= s7_nmag_ff;
         s8_zero_ff <= s7_dzero_ff;
         s9_den_ff  <= s9_den_in;
         s9_nmag_ff <= s8_nmag_ff;
         s9_neg_ff  <= s8_neg_ff;
         s9_zero_ff <= s8_zero_ff;
         dv_ff         <= dv_in;
         dv_den_ff[0]  <= s9_den_ff;
         dv_neg_ff[0]  <= s9_neg_ff;
         dv_zero_ff[0] <= s9_zero_ff;
         for (int d = 1; d <= QB; d++) begin
            dv_den_ff[d]  <= dv_den_ff[d-1];
            dv_neg_ff[d]  <= dv_neg_ff[d-1];
            dv_zero_ff[d] <= dv_zero_ff[d-1];
         end
         fin_data_ff <= fin_data_in;
         fin_stat_ff <= fin_stat_in;
      end
   end

   // output register and skid word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff  <= vld_ff[FIN];
         end
      end else if (vld_ff[FIN]) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_data_ff <= skid_data_ff;
            out_stat_ff <= skid_stat_ff;
         end else begin
            out_data_ff <= fin_data_ff;
            out_stat_ff <= fin_stat_ff;
         end
      end else if (en) begin
         skid_data_ff <= fin_data_ff;
         skid_stat_ff <= fin_stat_ff;
      end
   end

endmodule

// ----- tb/q_to_hkl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_to_hkl_checker
// watches the request, response and register channels of the q to hkl core,
// keeps its own copy of the goniometer and lattice rows, works out the hkl
// word and status for every accepted q word and compares each response
// word field by field with the oldest prediction
// ----------------------------------------------------------------------------
module q_to_hkl_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [3*qhkl_pkg::Q_WIDTH-1:0]      req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [3*qhkl_pkg::Q_WIDTH-1:0]      rsp_tdata,
   input  logic [qhkl_pkg::STATUS_W-1:0]       rsp_tuser,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [qhkl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qhkl_pkg::CSR_W-1:0]          csr_data,
   output int                                  fail_count,
   output int                                  hkl_pending
);

   localparam int W = qhkl_pkg::Q_WIDTH;

   typedef struct packed {
      logic [W-1:0]                  h;
      logic [W-1:0]                  k;
      logic [W-1:0]                  l;
      logic [qhkl_pkg::STATUS_W-1:0] status;
   } hkl_word_type;

   logic [qhkl_pkg::CSR_W-1:0] rows [6];
   hkl_word_type               hkl_expected [$];

   function automatic longint slot_of(input logic [qhkl_pkg::CSR_W-1:0] row, input int k);
      logic signed [qhkl_pkg::SLOT_W-1:0] v;
      v = row[k*qhkl_pkg::SLOT_W +: qhkl_pkg::SLOT_W];
      return longint'(v);
   endfunction

   function automatic logic signed [127:0] wide(input longint v);
      return 128'(v);
   endfunction

   function automatic hkl_word_type predict_hkl(input logic [3*W-1:0] qv);
      longint m [3][3];
      longint adj [3][3];
      longint qs [3];
      longint s;
      logic signed [W-1:0] qf;
      logic signed [127:0] det, num;
      logic [127:0] dmag, den, nmag;
      logic [191:0] dividend, quo, rem, lim;
      logic [W-1:0] res [3];
      logic sat, neg;
      hkl_word_type r;
      for (int i = 0; i < 3; i++) begin
         qf = qv[i*W +: W];
         qs[i] = longint'(qf);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s = 0;
            for (int k = 0; k < 3; k++) s += slot_of(rows[i], k) * slot_of(rows[3+k], j);
            m[i][j] = (s + (64'sd1 <<< 17)) >>> 18;
         end
      end
      adj[0][0] = m[1][1]*m[2][2] - m[1][2]*m[2][1];
      adj[0][1] = m[0][2]*m[2][1] - m[0][1]*m[2][2];
      adj[0][2] = m[0][1]*m[1][2] - m[0][2]*m[1][1];
      adj[1][0] = m[1][2]*m[2][0] - m[1][0]*m[2][2];
      adj[1][1] = m[0][0]*m[2][2] - m[0][2]*m[2][0];
      adj[1][2] = m[0][2]*m[1][0] - m[0][0]*m[1][2];
      adj[2][0] = m[1][0]*m[2][1] - m[1][1]*m[2][0];
      adj[2][1] = m[0][1]*m[2][0] - m[0][0]*m[2][1];
      adj[2][2] = m[0][0]*m[1][1] - m[0][1]*m[1][0];
      det = wide(m[0][0])*wide(adj[0][0]) + wide(m[0][1])*wide(adj[1][0])
          + wide(m[0][2])*wide(adj[2][0]);
      if (det == 0) begin
         r.h = '0;
         r.k = '0;
         r.l = '0;
         r.status = qhkl_pkg::STATUS_SINGULAR;
         return r;
      end
      dmag = det[127] ? -det : det;
      den  = dmag * 128'(qhkl_pkg::TWO_PI_Q);
      sat  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         num = wide(adj[i][0])*wide(qs[0]) + wide(adj[i][1])*wide(qs[1])
             + wide(adj[i][2])*wide(qs[2]);
         neg  = num[127] ^ det[127];
         nmag = num[127] ? -num : num;
         dividend = 192'(nmag) << qhkl_pkg::EXTRA_SHIFT;
         quo = dividend / 192'(den);
         rem = dividend - quo * 192'(den);
         if ((rem << 1) >= 192'(den)) quo = quo + 192'd1;
         lim = neg ? (192'd1 << (W-1)) : (192'd1 << (W-1)) - 192'd1;
         if (quo > lim) begin
            sat = 1'b1;
            res[i] = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end else begin
            res[i] = neg ? -quo[W-1:0] : quo[W-1:0];
         end
      end
      r.h = res[0];
      r.k = res[1];
      r.l = res[2];
      r.status = sat ? qhkl_pkg::STATUS_SAT : qhkl_pkg::STATUS_OK;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s at %0t: got %h, want %h", what, $realtime, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      hkl_word_type w;
      if (reset) begin
         rows[0] <= qhkl_pkg::ROW0_RESET;
         rows[1] <= qhkl_pkg::ROW1_RESET;
         rows[2] <= qhkl_pkg::ROW2_RESET;
         rows[3] <= qhkl_pkg::ROW0_RESET;
         rows[4] <= qhkl_pkg::ROW1_RESET;
         rows[5] <= qhkl_pkg::ROW2_RESET;
         hkl_expected.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index < 3'd6) rows[csr_index] <= csr_data;
         if (req_tvalid && req_tready) hkl_expected.push_back(predict_hkl(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (hkl_expected.size() == 0) begin
               report_mismatch("unexpected word", 64'(rsp_tdata), 64'(rsp_tuser));
            end else begin
               w = hkl_expected.pop_front();
               if (rsp_tdata[0 +: W] !== w.h)
                  report_mismatch("index_h", 64'(rsp_tdata[0 +: W]), 64'(w.h));
               if (rsp_tdata[W +: W] !== w.k)
                  report_mismatch("index_k", 64'(rsp_tdata[W +: W]), 64'(w.k));
               if (rsp_tdata[2*W +: W] !== w.l)
                  report_mismatch("index_l", 64'(rsp_tdata[2*W +: W]), 64'(w.l));
               if (rsp_tuser !== w.status)
                  report_mismatch("status", 64'(rsp_tuser), 64'(w.status));
            end
         end
      end
      hkl_pending <= hkl_expected.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the q to hkl core: steps through identity, extreme, singular
// and random matrix settings, sends directed and random q words with random
// gaps and response stalls, and leaves all checking to the checker
// ----------------------------------------------------------------------------
module tb;

   localparam int W  = qhkl_pkg::Q_WIDTH;
   localparam int SW = qhkl_pkg::SLOT_W;
   localparam int CR = qhkl_pkg::CSR_W;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [3*W-1:0]                    req_tdata = '0;   // q_x, q_y, q_z
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [3*W-1:0]                    rsp_tdata;        // index_h, index_k, index_l
   logic [qhkl_pkg::STATUS_W-1:0]     rsp_tuser;        // status
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [qhkl_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [CR-1:0]                     csr_data = '0;
   int                                fail_count;
   int                                hkl_pending;
   bit                                gaps_on = 1'b0;
   bit                                stalls_on = 1'b0;
   int                                stall_left = 0;

   localparam logic [SW-1:0] ONE_Q    = 21'h040000;
   localparam logic [SW-1:0] MOST_NEG = 21'h100000;
   localparam logic [SW-1:0] MOST_POS = 21'h0FFFFF;

   always #10 clock = ~clock;

   q_to_hkl_transform_core u_dut (.*);

   q_to_hkl_checker u_checker (.*);

   // response back-pressure
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (rsp_tvalid && rsp_tready) begin
         n = stalls_on ? $urandom_range(0, 11) : 0;
         stall_left <= n;
         rsp_tready <= (n == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [CR-1:0] pack_row(input logic [SW-1:0] e0,
                                              input logic [SW-1:0] e1,
                                              input logic [SW-1:0] e2);
      return {e2, e1, e0};
   endfunction

   task automatic write_reg(input logic [qhkl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [CR-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (hkl_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_matrices(input logic [CR-1:0] r0, input logic [CR-1:0] r1,
                               input logic [CR-1:0] r2, input logic [CR-1:0] b0,
                               input logic [CR-1:0] b1, input logic [CR-1:0] b2);
      drain();
      write_reg(qhkl_pkg::CSR_GONIO_ROW0, r0);
      write_reg(qhkl_pkg::CSR_GONIO_ROW1, r1);
      write_reg(qhkl_pkg::CSR_GONIO_ROW2, r2);
      write_reg(qhkl_pkg::CSR_LAT_ROW0, b0);
      write_reg(qhkl_pkg::CSR_LAT_ROW1, b1);
      write_reg(qhkl_pkg::CSR_LAT_ROW2, b2);
   endtask

   task automatic send_q(input logic [W-1:0] qx, input logic [W-1:0] qy,
                         input logic [W-1:0] qz);
      int gap;
      gap = gaps_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {qz, qy, qx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [W-1:0] rand_q();
      case ($urandom_range(0, 5))
         0: return {1'b0, {(W-1){1'b1}}};
         1: return {1'b1, {(W-1){1'b0}}};
         2, 3: return W'($signed($urandom_range(0, 1 << 24)) - (1 <<< 23));
         default: return W'($urandom());
      endcase
   endfunction

   function automatic logic [SW-1:0] near(input logic [SW-1:0] base);
      return base + SW'($urandom_range(0, 1 << 16)) - SW'(1 << 15);
   endfunction

   function automatic logic [CR-1:0] rand_row(input int diag, input bit wild);
      logic [SW-1:0] e [3];
      for (int k = 0; k < 3; k++) begin
         if (wild) e[k] = SW'($urandom());
         else e[k] = near(k == diag ? ($urandom_range(0, 1) ? ONE_Q : -ONE_Q) : '0);
      end
      return pack_row(e[0], e[1], e[2]);
   endfunction

   task automatic random_burst(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) gaps_on = ~gaps_on;
         if ($urandom_range(0, 7) == 0) stalls_on = ~stalls_on;
         send_q(rand_q(), rand_q(), rand_q());
      end
      end_burst();
   endtask

   initial begin
      logic [W-1:0] qmax, qmin;
      qmax = {1'b0, {(W-1){1'b1}}};
      qmin = {1'b1, {(W-1){1'b0}}};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity after reset: extremes and signs
      send_q('0, '0, '0);
      send_q(qmax, qmin, 32'h0010_0000);
      send_q(qmin, qmax, 32'hFFF0_0000);
      send_q(32'h0000_0001, 32'hFFFF_FFFF, 32'h0064_87ED);
      send_q(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0003);
      end_burst();

      // register indexes past the six are ignored
      drain();
      write_reg(3'd6, '1);
      write_reg(3'd7, {CR{1'b1}});
      send_q(32'h0100_0000, 32'hFF00_0000, 32'h0001_0000);
      end_burst();

      // extreme diagonal, saturating outputs
      set_matrices(pack_row(MOST_NEG, '0, '0), pack_row('0, MOST_POS, '0),
                   pack_row('0, '0, 21'h000001), pack_row(ONE_Q, '0, '0),
                   pack_row('0, ONE_Q, '0), pack_row('0, '0, ONE_Q));
      send_q(qmax, qmin, qmax);
      send_q(32'h0000_1000, 32'hFFFF_F000, 32'h0000_0001);
      send_q(qmin, qmax, qmin);
      send_q('0, '0, 32'hFFFF_FFFF);
      end_burst();

      // rows at the extremes, all ones and zero
      set_matrices({CR{1'b1}}, pack_row(MOST_NEG, MOST_NEG, MOST_NEG),
                   pack_row(MOST_POS, MOST_POS, MOST_POS), '0, {CR{1'b1}},
                   pack_row(MOST_POS, MOST_NEG, MOST_POS));
      send_q(qmax, qmax, qmin);
      send_q(32'h0000_0007, qmin, 32'h1234_5678);
      end_burst();

      // singular: zero row in the goniometer
      set_matrices(qhkl_pkg::ROW0_RESET, '0, qhkl_pkg::ROW2_RESET,
                   qhkl_pkg::ROW0_RESET, qhkl_pkg::ROW1_RESET, qhkl_pkg::ROW2_RESET);
      send_q(qmax, qmin, 32'h0010_0000);
      send_q(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
      end_burst();

      gaps_on = 1'b1;
      stalls_on = 1'b1;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 3)
            set_matrices(rand_row(0, 1), rand_row(1, 1), rand_row(2, 1),
                         rand_row(0, 1), rand_row(1, 1), rand_row(2, 1));
         else
            set_matrices(rand_row(0, 0), rand_row(1, 0), rand_row(2, 0),
                         rand_row(1, 0), rand_row(0, 0), rand_row(2, 0));
         random_burst(48);
      end

      // back to identity to finish
      set_matrices(qhkl_pkg::ROW0_RESET, qhkl_pkg::ROW1_RESET, qhkl_pkg::ROW2_RESET,
                   qhkl_pkg::ROW0_RESET, qhkl_pkg::ROW1_RESET, qhkl_pkg::ROW2_RESET);
      random_burst(20);

      drain();
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("tb failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/qhkl_pkg.sv
rtl/q_to_hkl_transform_core.sv
tb/q_to_hkl_checker.sv
tb/tb.sv
